@@ hw/rtl/dat_pkg.sv @@
package dat_pkg;

  // Field widths of the item and result words
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned RDATA_W  = 32;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    capture;
    logic    push_wr;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    rd_pos;
    logic    rd_idx;
    logic    shift_wr;
    logic    idx_load;
    logic    idx_inc;
    logic    out_load;
    logic    out_rdata;
    status_t out_status;
  } dat_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_t cmd;
    logic empty;
    logic full;
    logic pos_oob;
    logic pos_last;
    logic idx_last;
  } dat_sts_t;

endpackage

@@ hw/rtl/dat_dp.sv @@
module dat_dp
  import dat_pkg::*;
#(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dat_ctl_t                   ctl,
  output dat_sts_t                   sts,
  input  logic [CMD_W-1:0]           in_command,
  input  logic [POS_W-1:0]           in_position,
  input  logic signed [VALUE_W-1:0]  in_value,
  output logic signed [RDATA_W-1:0]  out_read_data,
  output logic [COUNT_W-1:0]         out_entry_count,
  output logic                       out_is_empty,
  output logic [STATUS_W-1:0]        out_status
);

  localparam int unsigned AW   = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  // Entry store
  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] mem_q_r;

  // Captured word and bookkeeping
  cmd_t                  cmd_r;
  logic [POS_W-1:0]      pos_r;
  logic [VALUE_W-1:0]    val_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic [CW-1:0]         idx_r;
  logic [CW-1:0]         idx_nxt;

  logic [CMPW-1:0]       pos_ext;
  logic [CMPW:0]         pos_plus1;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  wr_en;
  logic                  rd_en;

  assign pos_ext   = CMPW'(pos_r);
  assign pos_plus1 = {1'b0, pos_ext} + (CMPW + 1)'(1);

  // Status toward the controller
  assign sts.cmd      = cmd_r;
  assign sts.empty    = (count_r == '0);
  assign sts.full     = (count_r == CW'(CAPACITY));
  assign sts.pos_oob  = (pos_ext >= CMPW'(count_r));
  assign sts.pos_last = (pos_plus1 == (CMPW + 1)'(count_r));
  assign sts.idx_last = (CW'(idx_r + 1'b1) == count_r);

  // Select memory port addresses and data
  assign rd_en   = ctl.rd_pos | ctl.rd_idx;
  assign rd_addr = ctl.rd_pos ? AW'(pos_ext) : AW'(idx_r);
  assign wr_en   = ctl.push_wr | ctl.shift_wr;
  assign wr_addr = ctl.push_wr ? AW'(count_r) : AW'(idx_r - 1'b1);
  assign wr_data = ctl.push_wr ? DATA_WIDTH'(val_r) : mem_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Advance count and shift index
  always_comb begin
    count_nxt = count_r;
    if (ctl.cnt_inc) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (ctl.cnt_dec) begin
      count_nxt = CW'(count_r - 1'b1);
    end
    idx_nxt = idx_r;
    if (ctl.idx_load) begin
      idx_nxt = CW'(pos_plus1);
    end else if (ctl.idx_inc) begin
      idx_nxt = CW'(idx_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Hold the accepted word, shift index and result word
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (ctl.capture) begin
      cmd_r <= cmd_t'(in_command);
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (ctl.out_load) begin
      out_read_data   <= ctl.out_rdata ? RDATA_W'(mem_q_r) : '0;
      out_entry_count <= COUNT_W'(count_r);
      out_is_empty    <= (count_r == '0);
      out_status      <= ctl.out_status;
    end
  end

endmodule

@@ hw/rtl/dat_ctrl.sv @@
module dat_ctrl
  import dat_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dat_sts_t sts,
  output dat_ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_t;

  state_t  state_r, state_nxt;
  logic    out_valid_r, out_valid_nxt;
  status_t status_r, status_nxt;
  logic    rdsel_r, rdsel_nxt;

  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != S_IDLE);

  // Sequence one command at a time
  always_comb begin
    ctl            = '0;
    ctl.out_status = status_r;
    ctl.out_rdata  = rdsel_r;
    state_nxt      = state_r;
    status_nxt     = status_r;
    rdsel_nxt      = rdsel_r;
    out_valid_nxt  = out_valid_r & out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = ST_OK;
        rdsel_nxt  = 1'b0;
        state_nxt  = S_DONE;
        case (sts.cmd)
          CMD_PUSH: begin
            if (sts.full) begin
              status_nxt = ST_FULL;
            end else begin
              ctl.push_wr = 1'b1;
              ctl.cnt_inc = 1'b1;
            end
          end
          CMD_POP: begin
            if (sts.empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              ctl.cnt_dec = 1'b1;
            end
          end
          CMD_DELETE: begin
            if (sts.pos_oob) begin
              status_nxt = ST_RANGE;
            end else if (sts.pos_last) begin
              ctl.cnt_dec = 1'b1;
            end else begin
              ctl.idx_load = 1'b1;
              state_nxt    = S_SH_RD;
            end
          end
          CMD_READ: begin
            if (sts.pos_oob) begin
              status_nxt = ST_RANGE;
            end else begin
              ctl.rd_pos = 1'b1;
              rdsel_nxt  = 1'b1;
            end
          end
          default: begin
            status_nxt = ST_OK;
          end
        endcase
      end
      S_SH_RD: begin
        ctl.rd_idx = 1'b1;
        state_nxt  = S_SH_WR;
      end
      S_SH_WR: begin
        // move entry idx down to idx-1
        ctl.shift_wr = 1'b1;
        ctl.idx_inc  = 1'b1;
        if (sts.idx_last) begin
          ctl.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_SH_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          ctl.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      status_r    <= ST_OK;
      rdsel_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      rdsel_r     <= rdsel_nxt;
    end
  end

endmodule

@@ hw/rtl/dynamic_array_table.sv @@
// Channel  Handshake            Fields
// in_      in_valid / in_stall  command, position, value
// out_     out_valid/out_stall  read_data, entry_count, is_empty, status
//
// Every command passes from idle through the execute state to the done state,
// which loads the result register unless a held result blocks it; only then is the
// next word taken. Read data comes from the registered entry memory port.
// A delete adds shift states before done: the entry memory moves each later entry
// down one place with a read state and a write state.
// Synchronous active-low reset clears the entry count; entries hold no reset.
// A held result waits in the output register while the next word is taken.
module dynamic_array_table
  import dat_pkg::*;
#(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CMD_W-1:0]           in_command,
  input  logic [POS_W-1:0]           in_position,
  input  logic signed [VALUE_W-1:0]  in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [RDATA_W-1:0]  out_read_data,
  output logic [COUNT_W-1:0]         out_entry_count,
  output logic                       out_is_empty,
  output logic [STATUS_W-1:0]        out_status
);

  dat_ctl_t ctl;
  dat_sts_t sts;

  // Sequence commands
  dat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Store entries and build results
  dat_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_command      (in_command),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_read_data   (out_read_data),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_status      (out_status)
  );

endmodule

@@ bench/dat_array_checker.sv @@
module dat_array_checker
  import dat_pkg::*;
#(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [CMD_W-1:0]          in_command,
  input  logic [POS_W-1:0]          in_position,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [RDATA_W-1:0] out_read_data,
  input  logic [COUNT_W-1:0]        out_entry_count,
  input  logic                      out_is_empty,
  input  logic [STATUS_W-1:0]       out_status,
  output int unsigned               fail_count,
  output int unsigned               outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [RDATA_W-1:0] read_data;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_empty;
    status_t                   status;
  } array_result_t;

  // Shadow copy of the packed array
  logic [DATA_WIDTH-1:0] stored_words [CAPACITY];
  int unsigned           stored_count = 0;

  array_result_t expected_results [$];
  int unsigned   mismatches = 0;

  // Apply one command to the shadow array and return the result word it yields
  function automatic array_result_t apply_array_command(input cmd_t op,
                                                        input logic [POS_W-1:0] pos,
                                                        input logic [VALUE_W-1:0] val);
    array_result_t res;
    res.read_data = '0;
    res.status    = ST_OK;
    case (op)
      CMD_PUSH: begin
        if (stored_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          stored_words[stored_count] = val[DATA_WIDTH-1:0];
          stored_count++;
        end
      end
      CMD_POP: begin
        if (stored_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          stored_count--;
        end
      end
      CMD_DELETE: begin
        if (pos >= stored_count) begin
          res.status = ST_RANGE;
        end else begin
          // close the gap: move every later entry down one place
          for (int unsigned i = pos + 1; i < stored_count; i++) begin
            stored_words[i-1] = stored_words[i];
          end
          stored_count--;
        end
      end
      default: begin
        if (pos >= stored_count) begin
          res.status = ST_RANGE;
        end else begin
          res.read_data = stored_words[pos];
        end
      end
    endcase
    res.entry_count = COUNT_W'(stored_count);
    res.is_empty    = (stored_count == 0);
    return res;
  endfunction

  // Compare result words, then predict for accepted input words
  always @(posedge clk) begin : watch
    array_result_t got;
    array_result_t want;
    if (!rst_n) begin
      stored_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_read_data, out_entry_count, out_is_empty, status_t'(out_status)};
        if (expected_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result word with nothing expected: data=%h count=%0d empty=%b st=%0d",
                     $realtime, got.read_data, got.entry_count, got.is_empty, got.status);
          end
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("%0t: exp/got data %h/%h count %0d/%0d empty %b/%b status %0d/%0d",
                       $realtime, want.read_data, got.read_data, want.entry_count,
                       got.entry_count, want.is_empty, got.is_empty, want.status, got.status);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(),
                                apply_array_command(cmd_t'(in_command), in_position,
                                                    in_value));
      end
    end
    outstanding <= expected_results.size();
    fail_count  <= mismatches;
  end

endmodule

@@ bench/dynamic_array_table_test.sv @@
module dynamic_array_table_test;
  import dat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY    = 256;
  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned WORD_TARGET = 800;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [CMD_W-1:0]          in_command = CMD_PUSH;
  logic [POS_W-1:0]          in_position = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [RDATA_W-1:0] out_read_data;
  logic [COUNT_W-1:0]        out_entry_count;
  logic                      out_is_empty;
  logic [STATUS_W-1:0]       out_status;

  int unsigned fail_count;
  int unsigned outstanding;

  // Sender bookkeeping: fill level steers positions, not checking
  int unsigned array_level = 0;
  int unsigned words_sent = 0;
  int unsigned tx_calm_left = 0;

  // Receiver pacing; hold_requests bumps start a long hold-off
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned stall_left = 0;
  int unsigned rx_calm_left = 0;

  int unsigned cycles_run = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dynamic_array_table #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_data   (out_read_data),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_status      (out_status)
  );

  dat_array_checker #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_data   (out_read_data),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_status      (out_status),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  // Pace the result side: short stalls, a few long ones, calm stretches
  always @(posedge clk) begin : rx_pacing
    int unsigned r;
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      stall_left   = LONG_HOLD;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rx_calm_left != 0 || !rst_n) begin
      if (rx_calm_left != 0) rx_calm_left--;
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall <= 1'b0;
      end else if (r < 85) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else if (r < 92) begin
        stall_left = $urandom_range(8, 40);
        out_stall <= 1'b1;
      end else begin
        rx_calm_left = $urandom_range(20, 120);
        out_stall <= 1'b0;
      end
    end
  end

  // Pick the idle gap before the next input word
  function automatic int unsigned next_gap();
    int unsigned r;
    if (tx_calm_left != 0) begin
      tx_calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 62) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(6, 40);
    tx_calm_left = $urandom_range(20, 80);
    return 0;
  endfunction

  // Offer one word after a gap, hold it until accepted, then track the level
  task automatic send_word(input cmd_t op, input logic [POS_W-1:0] pos,
                           input logic [VALUE_W-1:0] val);
    int unsigned gap;
    gap = next_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= op;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    case (op)
      CMD_PUSH:   if (array_level < CAPACITY) array_level++;
      CMD_POP:    if (array_level != 0) array_level--;
      CMD_DELETE: if (pos < array_level) array_level--;
      default:    ;
    endcase
  endtask

  // Drop valid and hold until every expected result word has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Mostly in range, sometimes just past the end, sometimes anywhere
  function automatic logic [POS_W-1:0] random_position();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (array_level != 0 && r < 7) return POS_W'($urandom_range(0, array_level - 1));
    if (array_level < CAPACITY && r < 9) return POS_W'(array_level);
    return POS_W'($urandom_range(0, 255));
  endfunction

  // Mixed commands around a small fill level, so deletes stay cheap
  task automatic churn_round(input int unsigned n);
    int unsigned r;
    int unsigned push_w;
    for (int unsigned i = 0; i < n; i++) begin
      r      = $urandom_range(0, 99);
      push_w = (array_level > 24) ? 20 : 40;
      if (r < push_w) begin
        send_word(CMD_PUSH, POS_W'($urandom), $urandom);
      end else if (r < push_w + 20) begin
        send_word(CMD_POP, POS_W'($urandom), $urandom);
      end else if (r < push_w + 45) begin
        send_word(CMD_DELETE, random_position(), $urandom);
      end else begin
        send_word(CMD_READ, random_position(), $urandom);
      end
    end
  endtask

  // Bound the run
  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("dynamic_array_table regression: fail");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Errors on an empty array
    send_word(CMD_POP, 8'hA5, 32'h1234_5678);
    send_word(CMD_READ, 8'h00, 32'hFFFF_FFFF);
    send_word(CMD_DELETE, 8'h00, 32'h0);
    // Extreme values; position ignored on push
    send_word(CMD_PUSH, 8'hFF, 32'h7FFF_FFFF);
    send_word(CMD_PUSH, 8'h00, 32'h8000_0000);
    send_word(CMD_PUSH, 8'h5A, 32'h0000_0000);
    send_word(CMD_PUSH, 8'hFF, 32'hFFFF_FFFF);
    send_word(CMD_READ, 8'd0, 32'hDEAD_BEEF);
    send_word(CMD_READ, 8'd3, 32'h0);
    // Position at the count and far past it
    send_word(CMD_READ, 8'd4, 32'h0);
    send_word(CMD_READ, 8'd255, 32'h0);
    send_word(CMD_DELETE, 8'd4, 32'h0);
    // Delete in the middle with a value that must be ignored
    send_word(CMD_DELETE, 8'd1, 32'hCAFE_F00D);
    send_word(CMD_READ, 8'd1, 32'h0);
    // Delete the last entry, then pop with junk fields
    send_word(CMD_DELETE, 8'd2, 32'h0);
    send_word(CMD_POP, 8'hFF, 32'hFFFF_FFFF);
    send_word(CMD_READ, 8'd0, 32'h0);
    send_word(CMD_POP, 8'h00, 32'h0);
    send_word(CMD_POP, 8'h00, 32'h0);
    send_word(CMD_READ, 8'd0, 32'h0);

    churn_round(80);

    // Fill to capacity while the receiver holds off
    hold_requests <= hold_requests + 1;
    while (array_level < CAPACITY) begin
      if ($urandom_range(0, 4) == 0) begin
        send_word(CMD_READ, random_position(), $urandom);
      end else begin
        send_word(CMD_PUSH, POS_W'($urandom), $urandom);
      end
    end
    repeat (3) send_word(CMD_PUSH, POS_W'($urandom), $urandom);
    send_word(CMD_READ, 8'd255, 32'h0);
    send_word(CMD_READ, 8'd0, 32'h0);
    repeat (20) send_word(CMD_READ, POS_W'($urandom), $urandom);
    send_word(CMD_DELETE, 8'd255, 32'h0);
    send_word(CMD_PUSH, 8'h00, $urandom);
    // Longest shift: delete the first entry of a full array
    send_word(CMD_DELETE, 8'd0, 32'h0);
    send_word(CMD_READ, 8'd0, 32'h0);
    send_word(CMD_READ, 8'd254, 32'h0);
    send_word(CMD_READ, 8'd255, 32'h0);
    wait_results_drained();

    // Drain near the end so deletes stay short
    while (array_level > 8) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_word(CMD_POP, POS_W'($urandom), $urandom);
        5, 6, 7: send_word(CMD_DELETE,
                           POS_W'(array_level - 1 - $urandom_range(0, 3)), $urandom);
        default: send_word(CMD_READ, random_position(), $urandom);
      endcase
    end

    hold_requests <= hold_requests + 1;
    while (words_sent < WORD_TARGET) churn_round(40);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("dynamic_array_table regression: pass");
    end else begin
      $display("dynamic_array_table regression: fail");
    end
    $finish;
  end

endmodule
